// ===== rtl/cau_pkg.sv =====
// Shared types for the complex arithmetic unit.
// Operation and status codes; no dependencies.
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_OVF = 2'd2
  } status_t;

endpackage

// ===== rtl/cau_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per stage.
// Standalone; chained by complex_arithmetic_unit.
module cau_div_cell #(
  parameter int RW = 65,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [RW-1:0] den_i,
  input  logic [QW-1:0] q_i,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] low_o,
  output logic [RW-1:0] den_o,
  output logic [QW-1:0] q_o
);

  logic [RW:0] rs;
  logic [RW:0] dx;
  logic [RW:0] rn;
  logic        ge;

  always_comb begin
    rs = {rem_i, low_i[QW-1]};
    dx = {1'b0, den_i};
    ge = (rs >= dx);
    rn = ge ? (rs - dx) : rs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rn[RW-1:0];
      low_o <= low_i << 1;
      den_o <= den_i;
      q_o   <= {q_i[QW-2:0], ge};
    end
  end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// Channel  Dir  tdata (low bit up)                    tuser
// in_      in   a_re, a_im, b_re, b_im                operation
// out_     out  res_re, res_im                        status
// One transaction per cycle sustained while out_ does not stall.
// Front: multiply, combine, magnitude, divider prep with non-divide saturation;
// then one divider cell per quotient bit; then quotient saturation into the output register.
// Reset clears the valid line only. A stall on out_ holds every stage.
// Top level of the complex arithmetic unit; uses cau_pkg and cau_div_cell.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  localparam int IN_TW     = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TW-1:0]      in_tdata,   // a_re, a_im, b_re, b_im
  input  cau_pkg::op_t          in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TW-1:0]     out_tdata,  // res_re, res_im
  output cau_pkg::status_t      out_tuser   // status
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int NW = SW;
  localparam int DW = SW;
  localparam int QW = W;
  localparam int MW = NW + F;
  localparam int IW = MW - QW;
  localparam int CW = (IW > DW) ? IW : DW;
  localparam int NF = 4;
  localparam int NS = NF + QW;

  typedef struct packed {
    logic         is_div;
    logic         dz;
    logic         ovf;
    logic [W-1:0] res_re;
    logic [W-1:0] res_im;
    logic         neg_re;
    logic         neg_im;
    logic         big_re;
    logic         big_im;
  } sb_t;

  function automatic logic [W:0] sat(input logic neg, input logic [NW-1:0] m,
                                     input logic big);
    logic [NW-1:0] lim_p;
    logic [NW-1:0] lim_n;
    logic [W:0]    r;
    lim_p = NW'({(W-1){1'b1}});
    lim_n = NW'(1) << (W-1);
    if (!neg) begin
      if (big || m > lim_p) r = {1'b1, 1'b0, {(W-1){1'b1}}};
      else                  r = {1'b0, m[W-1:0]};
    end else begin
      if (big || m > lim_n) r = {1'b1, 1'b1, {(W-1){1'b0}}};
      else                  r = {1'b0, (~m[W-1:0]) + W'(1)};
    end
    return r;
  endfunction

  logic en;
  logic [NS-1:0] vld_r;
  logic out_valid_r;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NS-2:0], in_tvalid};
      out_valid_r <= vld_r[NS-1];
    end
  end

  // multiply stage, with the add/subtract sums
  logic signed [W-1:0] a_re, a_im, b_re, b_im;
  assign a_re = in_tdata[W-1:0];
  assign a_im = in_tdata[2*W-1:W];
  assign b_re = in_tdata[3*W-1:2*W];
  assign b_im = in_tdata[4*W-1:3*W];

  op_t                 op1_r;
  logic signed [PW-1:0] prr_r, pii_r, pri_r, pir_r, pbb_r, pcc_r;
  logic signed [W:0]    sre_r, sim_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_tuser;
      prr_r <= a_re * b_re;
      pii_r <= a_im * b_im;
      pri_r <= a_re * b_im;
      pir_r <= a_im * b_re;
      pbb_r <= b_re * b_re;
      pcc_r <= b_im * b_im;
      if (in_tuser == OP_SUB) begin
        sre_r <= {a_re[W-1], a_re} - {b_re[W-1], b_re};
        sim_r <= {a_im[W-1], a_im} - {b_im[W-1], b_im};
      end else begin
        sre_r <= {a_re[W-1], a_re} + {b_re[W-1], b_re};
        sim_r <= {a_im[W-1], a_im} + {b_im[W-1], b_im};
      end
    end
  end

  // combine stage
  op_t                  op2_r;
  logic signed [SW-1:0] vre2_r, vim2_r, vre_nxt, vim_nxt;
  logic [DW-1:0]        den2_r;
  logic signed [SW-1:0] xrr, xii, xri, xir, xbb, xcc;

  always_comb begin
    xrr = {prr_r[PW-1], prr_r};
    xii = {pii_r[PW-1], pii_r};
    xri = {pri_r[PW-1], pri_r};
    xir = {pir_r[PW-1], pir_r};
    xbb = {pbb_r[PW-1], pbb_r};
    xcc = {pcc_r[PW-1], pcc_r};
    case (op1_r)
      OP_MUL: begin
        vre_nxt = xrr - xii;
        vim_nxt = xri + xir;
      end
      OP_DIV: begin
        vre_nxt = xrr + xii;
        vim_nxt = xir - xri;
      end
      default: begin
        vre_nxt = {{(SW-W-1){sre_r[W]}}, sre_r};
        vim_nxt = {{(SW-W-1){sim_r[W]}}, sim_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      vre2_r <= vre_nxt;
      vim2_r <= vim_nxt;
      den2_r <= DW'(xbb + xcc);
    end
  end

  // magnitude stage
  op_t           op3_r;
  logic          neg_re3_r, neg_im3_r;
  logic [NW-1:0] mag_re3_r, mag_im3_r;
  logic [DW-1:0] den3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r     <= op2_r;
      neg_re3_r <= vre2_r[SW-1];
      neg_im3_r <= vim2_r[SW-1];
      mag_re3_r <= vre2_r[SW-1] ? NW'(-vre2_r) : NW'(vre2_r);
      mag_im3_r <= vim2_r[SW-1] ? NW'(-vim2_r) : NW'(vim2_r);
      den3_r    <= den2_r;
    end
  end

  // divider prep and non-divide saturation
  logic [MW-1:0] m_re, m_im;
  logic [CW-1:0] top_re, top_im, denc;
  logic [NW-1:0] sh_re, sh_im;
  logic [W:0]    sat_re, sat_im;
  sb_t           sb_nxt;

  logic [DW-1:0] rem_re_c [0:QW];
  logic [DW-1:0] rem_im_c [0:QW];
  logic [QW-1:0] low_re_c [0:QW];
  logic [QW-1:0] low_im_c [0:QW];
  logic [DW-1:0] den_re_c [0:QW];
  logic [DW-1:0] den_im_c [0:QW];
  logic [QW-1:0] q_re_c   [0:QW];
  logic [QW-1:0] q_im_c   [0:QW];
  sb_t           sb_r     [0:QW];

  always_comb begin
    m_re   = MW'(mag_re3_r) << F;
    m_im   = MW'(mag_im3_r) << F;
    top_re = CW'(m_re >> QW);
    top_im = CW'(m_im >> QW);
    denc   = CW'(den3_r);
    sh_re  = (op3_r == OP_MUL) ? (mag_re3_r >> F) : mag_re3_r;
    sh_im  = (op3_r == OP_MUL) ? (mag_im3_r >> F) : mag_im3_r;
    sat_re = sat(neg_re3_r, sh_re, 1'b0);
    sat_im = sat(neg_im3_r, sh_im, 1'b0);
    sb_nxt.is_div = (op3_r == OP_DIV);
    sb_nxt.dz     = (den3_r == '0);
    sb_nxt.ovf    = sat_re[W] | sat_im[W];
    sb_nxt.res_re = sat_re[W-1:0];
    sb_nxt.res_im = sat_im[W-1:0];
    sb_nxt.neg_re = neg_re3_r;
    sb_nxt.neg_im = neg_im3_r;
    sb_nxt.big_re = (top_re >= denc);
    sb_nxt.big_im = (top_im >= denc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re_c[0] <= top_re[DW-1:0];
      rem_im_c[0] <= top_im[DW-1:0];
      low_re_c[0] <= m_re[QW-1:0];
      low_im_c[0] <= m_im[QW-1:0];
      den_re_c[0] <= den3_r;
      den_im_c[0] <= den3_r;
      q_re_c[0]   <= '0;
      q_im_c[0]   <= '0;
      sb_r[0]     <= sb_nxt;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    cau_div_cell #(.RW(DW), .QW(QW)) u_re (
      .clk(clk), .en(en),
      .rem_i(rem_re_c[k]), .low_i(low_re_c[k]), .den_i(den_re_c[k]), .q_i(q_re_c[k]),
      .rem_o(rem_re_c[k+1]), .low_o(low_re_c[k+1]), .den_o(den_re_c[k+1]),
      .q_o(q_re_c[k+1])
    );
    cau_div_cell #(.RW(DW), .QW(QW)) u_im (
      .clk(clk), .en(en),
      .rem_i(rem_im_c[k]), .low_i(low_im_c[k]), .den_i(den_im_c[k]), .q_i(q_im_c[k]),
      .rem_o(rem_im_c[k+1]), .low_o(low_im_c[k+1]), .den_o(den_im_c[k+1]),
      .q_o(q_im_c[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k+1] <= sb_r[k];
      end
    end
  end

  // output stage
  logic [W-1:0] res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  status_t      status_r, status_nxt;
  logic [W:0]   qs_re, qs_im;
  sb_t          sbl;

  always_comb begin
    sbl   = sb_r[QW];
    qs_re = sat(sbl.neg_re, NW'(q_re_c[QW]), sbl.big_re);
    qs_im = sat(sbl.neg_im, NW'(q_im_c[QW]), sbl.big_im);
    if (!sbl.is_div) begin
      res_re_nxt = sbl.res_re;
      res_im_nxt = sbl.res_im;
      status_nxt = sbl.ovf ? ST_OVF : ST_OK;
    end else if (sbl.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = ST_DZ;
    end else begin
      res_re_nxt = qs_re[W-1:0];
      res_im_nxt = qs_im[W-1:0];
      status_nxt = (qs_re[W] | qs_im[W]) ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tdata = OUT_TW'({res_im_r, res_re_r});
  assign out_tuser = status_r;

endmodule

// ===== tb/cau_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the complex arithmetic unit: watches the in_ and out_ channels,
// predicts each result in wide signed arithmetic and compares in order. Uses cau_pkg.
module cau_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  cau_pkg::op_t in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  cau_pkg::status_t out_tuser,
  output int           errors,
  output int           pending
);
  import cau_pkg::*;

  localparam int FRAC = 16;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    status_t            status;
  } cplx_result_t;

  cplx_result_t results_due[$];

  function automatic logic signed [31:0] clamp(logic signed [127:0] x, inout logic ovf);
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = 128'sh7fff_ffff;
    lo_lim = -128'sh8000_0000;
    if (x > hi_lim) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    if (x < lo_lim) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic cplx_result_t complex_op(op_t op, logic [127:0] d);
    logic signed [127:0] ar, ai, br, bi, xr, xi, den;
    logic ovf;
    cplx_result_t r;
    ar = $signed(d[31:0]);
    ai = $signed(d[63:32]);
    br = $signed(d[95:64]);
    bi = $signed(d[127:96]);
    ovf = 1'b0;
    case (op)
      OP_ADD: begin
        xr = ar + br;
        xi = ai + bi;
      end
      OP_SUB: begin
        xr = ar - br;
        xi = ai - bi;
      end
      OP_MUL: begin
        xr = (ar * br - ai * bi) / (128'sd1 <<< FRAC);
        xi = (ar * bi + ai * br) / (128'sd1 <<< FRAC);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.re = '0;
          r.im = '0;
          r.status = ST_DZ;
          return r;
        end
        xr = ((ar * br + ai * bi) <<< FRAC) / den;
        xi = ((ai * br - ar * bi) <<< FRAC) / den;
      end
    endcase
    r.re = clamp(xr, ovf);
    r.im = clamp(xi, ovf);
    r.status = ovf ? ST_OVF : ST_OK;
    return r;
  endfunction

  initial errors = 0;
  assign pending = results_due.size();

  always @(posedge clk) begin
    cplx_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        results_due.push_back(complex_op(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected transaction re=%h im=%h status=%0d", $time,
                   out_tdata[31:0], out_tdata[63:32], out_tuser);
        end else begin
          want = results_due.pop_front();
          if (want.re !== out_tdata[31:0] || want.im !== out_tdata[63:32] ||
              want.status !== out_tuser) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected re=%h im=%h status=%0d, got re=%h im=%h status=%0d",
                     $time, want.re, want.im, want.status,
                     out_tdata[31:0], out_tdata[63:32], out_tuser);
          end
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the complex arithmetic unit: directed and random operand
// transactions with random idling and back-pressure. Uses cau_pkg and cau_checker.
module testbench;
  import cau_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  op_t          in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  status_t      out_tuser;
  int           errors;
  int           pending;
  logic         steady;

  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hffff_0000;

  complex_arithmetic_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  cau_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h0;
      1: begin
        case ($urandom_range(5))
          0: return MAXV;
          1: return MINV;
          2: return ONE;
          3: return MONE;
          4: return 32'h1;
          default: return 32'hffff_ffff;
        endcase
      end
      2, 3: return $urandom;
      4: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      default: return {{14{1'($urandom_range(1))}}, 18'($urandom)};
    endcase
  endfunction

  task automatic send(op_t op, logic [31:0] ar, logic [31:0] ai,
                      logic [31:0] br, logic [31:0] bi);
    if (!steady && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {bi, br, ai, ar};
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver: random stalls, one long hold-off, and a stretch of constant ready
  initial begin
    int cyc;
    out_tready <= 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 2000 && cyc < 2300)
        out_tready <= 1'b0;
      else if (steady)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(99) >= 32);
    end
  end

  initial begin
    op_t op;
    logic [31:0] br, bi;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_ADD;
    steady    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_ADD, ONE, MONE, ONE, ONE);
    send(OP_ADD, MAXV, MAXV, 32'h1, MAXV);
    send(OP_ADD, MINV, MINV, MONE, 32'hffff_ffff);
    send(OP_SUB, MINV, 32'h0, 32'h1, MINV);
    send(OP_SUB, MAXV, 32'h5, MONE, 32'h7);
    send(OP_SUB, ONE, 32'h0, 32'h0003_0000, 32'h0002_0000);
    send(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, MONE);
    send(OP_MUL, MAXV, MAXV, MAXV, MAXV);
    send(OP_MUL, MINV, MINV, MINV, MINV);
    send(OP_MUL, MINV, 32'h0, MINV, 32'h0);
    send(OP_MUL, 32'hffff_fffd, 32'h1, 32'h3, 32'h0);
    send(OP_DIV, ONE, ONE, 32'h0, 32'h0);
    send(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    send(OP_DIV, 32'h0004_0000, 32'h0, 32'h0002_0000, 32'h0);
    send(OP_DIV, 32'h0003_0000, 32'h0, 32'h0, ONE);
    send(OP_DIV, ONE, 32'h0, ONE, ONE);
    send(OP_DIV, MAXV, MINV, 32'h1, 32'h0);
    send(OP_DIV, MINV, MINV, MINV, MINV);
    send(OP_DIV, MAXV, MAXV, 32'h0, 32'h1);
    send(OP_DIV, 32'hffff_fff9, 32'h3, MONE, 32'h0);
    send(OP_DIV, 32'h1, 32'h0, MAXV, MAXV);

    for (int i = 0; i < 1850; i++) begin
      steady = (i >= 700 && i < 1000);
      op = op_t'($urandom_range(3));
      br = pick_operand();
      bi = pick_operand();
      if (op == OP_DIV && $urandom_range(19) == 0) begin
        br = '0;
        bi = '0;
      end
      send(op, pick_operand(), pick_operand(), br, bi);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
